### hdl/tree_lca_distance_engine_assert.svh
// ============================================================================
// tree_lca_distance_engine_assert.svh
// assertion macros shared by the lca distance engine
// ============================================================================
`ifndef TREE_LCA_DISTANCE_ENGINE_ASSERT_SVH
`define TREE_LCA_DISTANCE_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TLDE_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TLDE_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### hdl/tlde_pkg.sv
// ============================================================================
// tlde_pkg
// field widths, saturation limits and controller/datapath command types
// ============================================================================
package tlde_pkg;

    localparam int NODE_W   = 12;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 28;
    localparam int DEPTH_W  = 12;
    localparam int LVL_W    = 5;

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic [DEPTH_W-1:0]  depth_t;

    localparam node_t  SENTINEL  = '0;
    localparam depth_t DEPTH_MAX = '1;
    localparam dist_t  DIST_MAX  = '1;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LD_BASE,
        OP_LD_WALK,
        OP_Q_DEPTH,
        OP_Q_LIFT,
        OP_Q_CMP,
        OP_Q_JUMP,
        OP_Q_PARENT,
        OP_Q_FINISH
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [LVL_W-1:0] lvl;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_query;
        logic in_load_ok;
        logic same_node;
        logic out_free;
    } status_t;

endpackage

### hdl/tlde_ifs.sv
// ============================================================================
// tlde_ifs
// request and response channels of the lca distance engine
// ============================================================================
interface tlde_req_if;
    import tlde_pkg::*;

    logic    valid;
    logic    ready;
    logic    mode;
    node_t   first_node;
    node_t   second_node;
    weight_t edge_weight;

    modport source (output valid, output mode, output first_node, output second_node,
                    output edge_weight, input ready);
    modport sink   (input valid, input mode, input first_node, input second_node,
                    input edge_weight, output ready);
endinterface

interface tlde_rsp_if;
    import tlde_pkg::*;

    logic  valid;
    logic  ready;
    node_t common_ancestor;
    dist_t path_distance;

    modport source (output valid, output common_ancestor, output path_distance, input ready);
    modport sink   (input valid, input common_ancestor, input path_distance, output ready);
endinterface

### hdl/tlde_ctrl.sv
// ============================================================================
// tlde_ctrl
// sequencer for node loads and lca queries, walks the ancestor levels
// ============================================================================
module tlde_ctrl #(
    parameter int LEVELS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tlde_pkg::status_t status,
    output tlde_pkg::cmd_t    cmd
);
    import tlde_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_LD_BASE  = 9'b000000010,
        ST_LD_WALK  = 9'b000000100,
        ST_Q_DEPTH  = 9'b000001000,
        ST_Q_LIFT   = 9'b000010000,
        ST_Q_CMP    = 9'b000100000,
        ST_Q_JUMP   = 9'b001000000,
        ST_Q_PARENT = 9'b010000000,
        ST_Q_FINISH = 9'b100000000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [LW-1:0] lvl_reg;
    logic [LW-1:0] lvl_next;
    op_t           op;

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        op         = OP_IDLE;
        case (state_reg)
            ST_IDLE:
            begin
                op = OP_IDLE;
                if (status.in_valid)
                begin
                    if (status.in_query)
                    begin
                        state_next = ST_Q_DEPTH;
                    end
                    else if (status.in_load_ok)
                    begin
                        state_next = ST_LD_BASE;
                    end
                end
            end
            ST_LD_BASE:
            begin
                op         = OP_LD_BASE;
                lvl_next   = LW'(1);
                state_next = (LEVELS > 1) ? ST_LD_WALK : ST_IDLE;
            end
            ST_LD_WALK:
            begin
                op = OP_LD_WALK;
                if (lvl_reg == LVL_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            ST_Q_DEPTH:
            begin
                op         = OP_Q_DEPTH;
                lvl_next   = '0;
                state_next = ST_Q_LIFT;
            end
            ST_Q_LIFT:
            begin
                op = OP_Q_LIFT;
                if (lvl_reg == LVL_LAST)
                begin
                    state_next = ST_Q_CMP;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            ST_Q_CMP:
            begin
                op         = OP_Q_CMP;
                lvl_next   = LVL_LAST;
                state_next = status.same_node ? ST_Q_FINISH : ST_Q_JUMP;
            end
            ST_Q_JUMP:
            begin
                op = OP_Q_JUMP;
                if (lvl_reg == '0)
                begin
                    state_next = ST_Q_PARENT;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            ST_Q_PARENT:
            begin
                op         = OP_Q_PARENT;
                state_next = ST_Q_FINISH;
            end
            ST_Q_FINISH:
            begin
                op = OP_Q_FINISH;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                op         = OP_IDLE;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lvl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
        end
    end

    assign cmd.op  = op;
    assign cmd.lvl = LVL_W'(lvl_reg);

endmodule

### hdl/tlde_datapath.sv
// ============================================================================
// tlde_datapath
// node tables, node pair registers, depth/distance arithmetic, result word
// ============================================================================
module tlde_datapath #(
    parameter int NODES  = 4096,
    parameter int LEVELS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    tlde_req_if.sink          request,
    tlde_rsp_if.source        response,
    input  tlde_pkg::cmd_t    cmd,
    output tlde_pkg::status_t status
);
    import tlde_pkg::*;

    localparam int DEPTH  = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
    localparam int AW     = $clog2(DEPTH);
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SUM_W  = DIST_W + 1;
    localparam int DIFF_W = (LEVELS > DEPTH_W) ? LEVELS : DEPTH_W;

    function automatic node_t clamp_node(input node_t n);
        return (32'(n) < NODES) ? n : SENTINEL;
    endfunction

    node_t             a_reg;
    node_t             a_next;
    node_t             b_reg;
    node_t             b_next;
    weight_t           weight_reg;
    logic [LEVELS-1:0] diff_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              out_valid_reg;
    node_t             out_node_reg;
    dist_t             out_dist_reg;

    node_t             rd_a [LEVELS];
    node_t             rd_b [LEVELS];
    depth_t            depth_mem [DEPTH];
    dist_t             dist_mem [DEPTH];
    depth_t            depth_qa;
    depth_t            depth_qb;
    dist_t             dist_qa;
    dist_t             dist_qb;

    logic              a_sentinel;
    logic              b_sentinel;
    depth_t            depth_a;
    depth_t            depth_b;
    dist_t             dist_a;
    dist_t             dist_b;
    logic [LW-1:0]     lvl;
    logic [LW-1:0]     walk_lvl;
    node_t             walk_node;
    logic              swap;
    depth_t            diff_depth;
    logic [DIFF_W-1:0] diff_wide;
    depth_t            depth_inc;
    logic [SUM_W-1:0]  dist_add;
    dist_t             dist_new;
    logic [SUM_W-1:0]  dist_sub;
    logic [SUM_W-1:0]  pd_full;
    dist_t             path_sat;
    logic              out_free;
    logic              out_load;
    logic              anc_we;
    logic [LW-1:0]     anc_wlvl;
    node_t             anc_wdata;
    logic              node_we;

    assign a_sentinel = (a_reg == SENTINEL);
    assign b_sentinel = (b_reg == SENTINEL);
    assign depth_a    = a_sentinel ? '0 : depth_qa;
    assign depth_b    = b_sentinel ? '0 : depth_qb;
    assign dist_a     = a_sentinel ? '0 : dist_qa;
    assign dist_b     = b_sentinel ? '0 : dist_qb;

    assign lvl       = cmd.lvl[LW-1:0];
    assign walk_lvl  = lvl - LW'(1);
    // a walk that comes back to the node being written sees its new entry
    assign walk_node = (a_reg == b_reg) ? a_reg : rd_a[walk_lvl];

    assign swap       = (depth_a < depth_b);
    assign diff_depth = swap ? (depth_b - depth_a) : (depth_a - depth_b);
    assign diff_wide  = DIFF_W'(diff_depth);

    assign depth_inc = (depth_a == DEPTH_MAX) ? DEPTH_MAX : (depth_a + 1'b1);
    assign dist_add  = {1'b0, dist_a} + SUM_W'(weight_reg);
    assign dist_new  = dist_add[SUM_W-1] ? DIST_MAX : dist_add[DIST_W-1:0];

    assign dist_sub = {dist_a, 1'b0};
    assign pd_full  = (sum_reg >= dist_sub) ? (sum_reg - dist_sub) : '0;
    assign path_sat = pd_full[SUM_W-1] ? DIST_MAX : pd_full[DIST_W-1:0];

    assign out_free = !out_valid_reg || response.ready;
    assign out_load = (cmd.op == OP_Q_FINISH) && out_free;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        anc_we    = 1'b0;
        anc_wlvl  = '0;
        anc_wdata = a_reg;
        node_we   = 1'b0;
        case (cmd.op)
            OP_IDLE:
            begin
                if (request.mode)
                begin
                    a_next = clamp_node(request.first_node);
                    b_next = clamp_node(request.second_node);
                end
                else
                begin
                    a_next = clamp_node(request.second_node);
                    b_next = request.first_node;
                end
            end
            OP_LD_BASE:
            begin
                node_we   = 1'b1;
                anc_we    = 1'b1;
                anc_wlvl  = '0;
                anc_wdata = a_reg;
            end
            OP_LD_WALK:
            begin
                anc_we    = 1'b1;
                anc_wlvl  = lvl;
                anc_wdata = walk_node;
                a_next    = walk_node;
            end
            OP_Q_DEPTH:
            begin
                if (swap)
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
            end
            OP_Q_LIFT:
            begin
                if (diff_reg[lvl])
                begin
                    a_next = rd_a[lvl];
                end
            end
            OP_Q_JUMP:
            begin
                if (rd_a[lvl] != rd_b[lvl])
                begin
                    a_next = rd_a[lvl];
                    b_next = rd_b[lvl];
                end
            end
            OP_Q_PARENT:
            begin
                a_next = rd_a[0];
            end
            default:
            begin
            end
        endcase
    end

    // one table per level, read at both next node values so data tracks a_reg/b_reg
    for (genvar g = 0; g < LEVELS; g++)
    begin : g_level
        node_t anc_mem [DEPTH];
        node_t qa;
        node_t qb;

        always_ff @(posedge clk)
        begin
            if (anc_we && (anc_wlvl == LW'(g)))
            begin
                anc_mem[b_reg[AW-1:0]] <= anc_wdata;
            end
            qa <= anc_mem[a_next[AW-1:0]];
            qb <= anc_mem[b_next[AW-1:0]];
        end

        assign rd_a[g] = a_sentinel ? SENTINEL : qa;
        assign rd_b[g] = b_sentinel ? SENTINEL : qb;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            depth_mem[b_reg[AW-1:0]] <= depth_inc;
            dist_mem[b_reg[AW-1:0]]  <= dist_new;
        end
        depth_qa <= depth_mem[a_next[AW-1:0]];
        depth_qb <= depth_mem[b_next[AW-1:0]];
        dist_qa  <= dist_mem[a_next[AW-1:0]];
        dist_qb  <= dist_mem[b_next[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        if (cmd.op == OP_IDLE)
        begin
            weight_reg <= request.edge_weight;
        end
        if (cmd.op == OP_Q_DEPTH)
        begin
            diff_reg <= diff_wide[LEVELS-1:0];
            sum_reg  <= {1'b0, dist_a} + {1'b0, dist_b};
        end
        if (out_load)
        begin
            out_node_reg <= a_reg;
            out_dist_reg <= path_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign request.ready            = (cmd.op == OP_IDLE);
    assign response.valid           = out_valid_reg;
    assign response.common_ancestor = out_node_reg;
    assign response.path_distance   = out_dist_reg;

    assign status.in_valid   = request.valid;
    assign status.in_query   = request.mode;
    assign status.in_load_ok = (request.first_node != SENTINEL)
                               && (32'(request.first_node) < NODES);
    assign status.same_node  = (a_reg == b_reg);
    assign status.out_free   = out_free;

endmodule

### hdl/tree_lca_distance_engine.sv
// ============================================================================
// tree_lca_distance_engine
// binary lifting lca and weighted path distance over a parent-first loaded tree
// ============================================================================
// request carries one word per item: mode 0 loads first_node with parent
// second_node and edge_weight, mode 1 asks for the lca and path distance of
// first_node and second_node. response carries one word per query, none per
// load. load a parent before its children; node 0 is the fixed root sentinel.
// a load first writes depth/distance and the level 0 ancestor entry, then
// reads the ancestor tables once per further level. a query runs the depth
// compare, lifts the deeper node, compares the pair and goes to the distance
// subtract when lifting alone met the other node, else makes the paired
// jump and a parent step before that subtract; the result word is registered
// and appears in the cycle after the subtract. the loop runs on the
// registered read of the per-level ancestor tables, one level per cycle.
// the result sits in an output register, so the next item is taken while it
// waits; a query whose result meets a stalled full register waits in its
// last step. reset clears the control state only, the tables need no clearing.
// ============================================================================
module tree_lca_distance_engine #(
    parameter int NODES  = 4096,
    parameter int LEVELS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    tlde_req_if.sink   request,
    tlde_rsp_if.source response
);
    import tlde_pkg::*;

    cmd_t    cmd;
    status_t status;

    tlde_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    tlde_datapath #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response),
        .cmd      (cmd),
        .status   (status)
    );

`include "tree_lca_distance_engine_assert.svh"

    `TLDE_ASSERT_NEXT(a_query_holds_input, request.valid && request.ready && request.mode, !request.ready, "query accepted but next word taken at once")
    `TLDE_ASSERT_NEXT(a_load_starts, request.valid && request.ready && !request.mode, cmd.op == OP_LD_BASE || cmd.op == OP_IDLE, "load accepted without starting a table write")
    `TLDE_ASSERT_NOW(a_result_from_query, $rose(response.valid), $past(cmd.op == OP_Q_FINISH), "result word without a finished query")

endmodule
